/* sv/mcl_pkg.sv */
`default_nettype none

package mcl_pkg;

    localparam int MAX_SAMPLES_DEF = 16384;
    localparam int SHIFT_BITS      = 12;
    localparam logic [7:0] TIMEOUT_LIMIT_RESET = 8'd50;

    localparam int READ_INDEX_W = 14;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 136;

    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_SAMPLE  = 3'd1,
        ACT_TIMEOUT = 3'd2,
        ACT_STOP    = 3'd3,
        ACT_ABORT   = 3'd4,
        ACT_READ    = 3'd5
    } t_action;

    typedef enum logic [3:0] {
        ST_IGNORED      = 4'd0,
        ST_STARTED      = 4'd1,
        ST_STORED       = 4'd2,
        ST_STORED_FULL  = 4'd3,
        ST_TIMEOUT      = 4'd4,
        ST_FINISHED     = 4'd5,
        ST_ALREADY_DONE = 4'd6,
        ST_NOT_RECORD   = 4'd7,
        ST_ERROR        = 4'd8,
        ST_READ_DATA    = 4'd9
    } t_status;

    typedef enum logic [1:0] {
        FLT_NONE    = 2'd0,
        FLT_EMPTY   = 2'd1,
        FLT_TIMEOUT = 2'd2,
        FLT_ABORTED = 2'd3
    } t_fault;

    // Everything the output stage needs from one processed word.
    typedef struct packed {
        t_status            status;
        logic [1:0]         phase;
        t_fault             fault;
        logic               rd_sel;
        logic signed [15:0] sample;
        logic [14:0]        total;
        logic [14:0]        peak;
        logic [31:0]        timeouts;
        logic [29:0]        sq;
        logic               sum_clr;
        logic               sum_add;
    } t_stage;

endpackage

`default_nettype wire

/* sv/mcl_store.sv */
`default_nettype none

module mcl_store #(
    parameter int DEPTH = mcl_pkg::MAX_SAMPLES_DEF,
    parameter int AW    = $clog2(mcl_pkg::MAX_SAMPLES_DEF)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire logic [15:0]       i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [AW-1:0]     i_rd_addr,
    output logic      [15:0]       o_rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* sv/mcl_ctrl.sv */
`default_nettype none

module mcl_ctrl #(
    parameter int MAX_SAMPLES = mcl_pkg::MAX_SAMPLES_DEF,
    parameter int AW          = $clog2(mcl_pkg::MAX_SAMPLES_DEF)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [7:0]          i_cfg_wr_data,
    input  wire logic                i_adv,
    input  wire logic                i_accept,
    input  wire logic [2:0]          i_action,
    input  wire logic signed [31:0]  i_raw_word,
    input  wire logic [mcl_pkg::READ_INDEX_W-1:0] i_read_index,
    output logic                     o_stg_valid,
    output mcl_pkg::t_stage          o_stg,
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output logic [15:0]              o_wr_data,
    output logic                     o_rd_en,
    output logic [AW-1:0]            o_rd_addr
);

    import mcl_pkg::*;

    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int CMPW = (CW > READ_INDEX_W) ? CW : READ_INDEX_W;
    localparam logic [CW-1:0]   COUNT_MAX = CW'(MAX_SAMPLES);
    localparam logic [CMPW-1:0] CMP_MAX   = CMPW'(MAX_SAMPLES);

    typedef enum logic [1:0] {
        PH_READY     = 2'd0,
        PH_RECORDING = 2'd1,
        PH_FINISHED  = 2'd2,
        PH_ERROR     = 2'd3
    } t_phase;

    t_phase      r_phase,    n_phase;
    t_fault      r_fault,    n_fault;
    logic [CW-1:0] r_count,  n_count;
    logic [14:0] r_peak,     n_peak;
    logic [31:0] r_timeouts, n_timeouts;
    logic [7:0]  r_in_row,   n_in_row;
    logic [7:0]  r_limit;
    logic        r_stg_valid;
    t_stage      r_stg,      n_stg;

    logic signed [31:0] shifted;
    logic signed [15:0] conv;
    logic        [15:0] neg;
    logic        [14:0] mag;
    logic        [CMPW-1:0] ridx_ext;
    logic        [CMPW-1:0] count_ext;
    logic        wr_en;
    logic        rd_en;

    // Shift, saturate to 16 bits, and fold -32768 onto the largest magnitude.
    always_comb begin
        shifted = i_raw_word >>> SHIFT_BITS;
        if (shifted > 32'sd32767) begin
            conv = 16'sh7fff;
        end else if (shifted < -32'sd32768) begin
            conv = 16'sh8000;
        end else begin
            conv = shifted[15:0];
        end
        neg = 16'(-conv);
        if (conv == 16'sh8000) begin
            mag = 15'h7fff;
        end else if (conv[15]) begin
            mag = neg[14:0];
        end else begin
            mag = conv[14:0];
        end
    end

    assign ridx_ext  = CMPW'(i_read_index);
    assign count_ext = CMPW'(r_count);

    always_comb begin
        n_phase    = r_phase;
        n_fault    = r_fault;
        n_count    = r_count;
        n_peak     = r_peak;
        n_timeouts = r_timeouts;
        n_in_row   = r_in_row;
        wr_en      = 1'b0;
        rd_en      = 1'b0;

        n_stg         = '0;
        n_stg.status  = ST_IGNORED;
        n_stg.sq      = 30'(mag) * 30'(mag);

        unique case (i_action)
            ACT_START: begin
                n_count       = '0;
                n_peak        = '0;
                n_timeouts    = '0;
                n_in_row      = '0;
                n_fault       = FLT_NONE;
                n_phase       = PH_RECORDING;
                n_stg.sum_clr = 1'b1;
                n_stg.status  = ST_STARTED;
            end
            ACT_SAMPLE: begin
                if (r_phase == PH_RECORDING && r_count < COUNT_MAX) begin
                    n_in_row      = '0;
                    wr_en         = 1'b1;
                    n_count       = r_count + 1'b1;
                    n_stg.sample  = conv;
                    n_stg.sum_add = 1'b1;
                    if (mag > r_peak) begin
                        n_peak = mag;
                    end
                    if (n_count == COUNT_MAX) begin
                        n_phase      = PH_FINISHED;
                        n_stg.status = ST_STORED_FULL;
                    end else begin
                        n_stg.status = ST_STORED;
                    end
                end
            end
            ACT_TIMEOUT: begin
                if (r_phase == PH_RECORDING) begin
                    n_timeouts = r_timeouts + 1'b1;
                    if (r_in_row >= r_limit) begin
                        n_phase      = PH_ERROR;
                        n_fault      = FLT_TIMEOUT;
                        n_stg.status = ST_ERROR;
                    end else begin
                        n_in_row     = r_in_row + 1'b1;
                        n_stg.status = ST_TIMEOUT;
                    end
                end
            end
            ACT_STOP: begin
                if (r_phase == PH_FINISHED) begin
                    n_stg.status = ST_ALREADY_DONE;
                end else if (r_phase != PH_RECORDING) begin
                    n_stg.status = ST_NOT_RECORD;
                end else if (r_count == '0) begin
                    n_phase      = PH_ERROR;
                    n_fault      = FLT_EMPTY;
                    n_stg.status = ST_ERROR;
                end else begin
                    n_phase      = PH_FINISHED;
                    n_stg.status = ST_FINISHED;
                end
            end
            ACT_ABORT: begin
                n_phase      = PH_ERROR;
                n_fault      = FLT_ABORTED;
                n_stg.status = ST_ERROR;
            end
            ACT_READ: begin
                if (ridx_ext < count_ext && ridx_ext < CMP_MAX) begin
                    rd_en        = 1'b1;
                    n_stg.rd_sel = 1'b1;
                    n_stg.status = ST_READ_DATA;
                end
            end
            default: begin
            end
        endcase

        n_stg.phase    = n_phase;
        n_stg.fault    = n_fault;
        n_stg.total    = 15'(n_count);
        n_stg.peak     = n_peak;
        n_stg.timeouts = n_timeouts;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_READY;
            r_fault     <= FLT_NONE;
            r_count     <= '0;
            r_peak      <= '0;
            r_timeouts  <= '0;
            r_in_row    <= '0;
            r_limit     <= TIMEOUT_LIMIT_RESET;
            r_stg_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (i_adv) begin
                r_stg_valid <= i_accept;
            end
            if (i_accept) begin
                r_phase    <= n_phase;
                r_fault    <= n_fault;
                r_count    <= n_count;
                r_peak     <= n_peak;
                r_timeouts <= n_timeouts;
                r_in_row   <= n_in_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_stg <= n_stg;
        end
    end

    assign o_stg_valid = r_stg_valid;
    assign o_stg       = r_stg;
    assign o_wr_en     = i_accept && wr_en;
    assign o_wr_addr   = r_count[AW-1:0];
    assign o_wr_data   = conv;
    assign o_rd_en     = i_accept && rd_en;
    assign o_rd_addr   = ridx_ext[AW-1:0];

endmodule

`default_nettype wire

/* sv/mic_capture_level_meter_unit.sv */
// Microphone capture front end with a level meter.
// Input words arrive on the s_axis channel (action, raw slot word, read index);
// each accepted word yields exactly one result word on the m_axis channel with
// the status, phase, error code, sample value and the running level figures.
// Samples are kept in a single-port-write, single-port-read store of
// MAX_SAMPLES entries; read-back words fetch from it through a registered
// read port. Throughput is one word per clock unless the output stalls. Each
// accepted word passes the state update and store access, then the
// squared-magnitude accumulation and the output register. When m_axis_tready
// is low with a result waiting, the whole pipeline holds and s_axis_tready
// drops; it rises again in the cycle the result is taken. The timeout limit is
// written through i_cfg_wr_en / i_cfg_wr_data while the block is idle, a user
// rule the block does not enforce. A synchronous reset (i_rst_n low) clears
// all counters, the phase to ready, the limit to 50 and empties the pipeline;
// sample store contents are not cleared and stay unreadable until rewritten.
`default_nettype none

module mic_capture_level_meter_unit #(
    parameter int MAX_SAMPLES = mcl_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [7:0]                        i_cfg_wr_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [2:0] action, [34:3] raw_word, [48:35] read_index, rest zero
    input  wire logic [mcl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [3:0] status, [5:4] phase, [7:6] error_code, [23:8] sample_value,
    // [38:24] sample_total, [53:39] peak_level, [97:54] energy_sum,
    // [129:98] timeout_total, rest zero
    output logic [mcl_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

    import mcl_pkg::*;

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    logic          adv;
    logic          accept;
    logic          stg_valid;
    t_stage        stg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;

    logic          r_o_valid;
    logic [OUT_TDATA_W-1:0] r_o_data;
    logic [43:0]   r_sq_sum, n_sq_sum;
    logic [15:0]   out_sample;

    assign adv           = !r_o_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && adv;
    assign s_axis_tready = adv;

    mcl_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .AW          (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_adv         (adv),
        .i_accept      (accept),
        .i_action      (s_axis_tdata[2:0]),
        .i_raw_word    (s_axis_tdata[34:3]),
        .i_read_index  (s_axis_tdata[48:35]),
        .o_stg_valid   (stg_valid),
        .o_stg         (stg),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr)
    );

    mcl_store #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // The energy sum lives here so the square gets its own register stage.
    always_comb begin
        if (stg.sum_clr) begin
            n_sq_sum = '0;
        end else if (stg.sum_add) begin
            n_sq_sum = r_sq_sum + 44'(stg.sq);
        end else begin
            n_sq_sum = r_sq_sum;
        end
        out_sample = stg.rd_sel ? rd_data : stg.sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_sq_sum  <= '0;
        end else if (adv) begin
            r_o_valid <= stg_valid;
            if (stg_valid) begin
                r_sq_sum <= n_sq_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && stg_valid) begin
            r_o_data <= {6'd0, stg.timeouts, n_sq_sum, stg.peak, stg.total,
                         out_sample, stg.fault, stg.phase, stg.status};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

endmodule

`default_nettype wire

/* test/tb_mic_capture_level_meter_unit.sv */
`default_nettype none

module tb_mic_capture_level_meter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mcl_pkg::*;

    // A small store makes the full-store case reachable many times per run.
    localparam int STORE_DEPTH = 48;

    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    localparam logic [1:0] PH_READY     = 2'd0;
    localparam logic [1:0] PH_RECORDING = 2'd1;
    localparam logic [1:0] PH_DONE      = 2'd2;
    localparam logic [1:0] PH_ERROR     = 2'd3;

    typedef struct packed {
        logic [13:0]        idx;
        logic signed [31:0] raw;
        logic [2:0]         act;
    } mic_word_t;

    // Laid out exactly as the result word, lowest field last.
    typedef struct packed {
        logic [31:0]        timeouts;
        logic [43:0]        energy;
        logic [14:0]        peak;
        logic [14:0]        total;
        logic signed [15:0] sample;
        t_fault             fault;
        logic [1:0]         phase;
        t_status            status;
    } meter_result_t;

    typedef struct packed {
        logic [2:0]         act;
        logic [31:0]        raw;
        logic [13:0]        idx;
        logic               typed;
        t_status            status;
        logic [1:0]         phase;
        t_fault             fault;
        logic signed [15:0] sample;
    } drill_row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [7:0]             i_cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [2:0] action, [34:3] raw_word, [48:35] read_index, rest zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [3:0] status, [5:4] phase, [7:6] error_code, [23:8] sample_value,
    // [38:24] sample_total, [53:39] peak_level, [97:54] energy_sum,
    // [129:98] timeout_total, rest zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    mic_capture_level_meter_unit #(
        .MAX_SAMPLES(STORE_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predicted capture state.
    logic signed [15:0] level_store [STORE_DEPTH];
    int                 cap_total;
    int                 cap_run;
    logic [14:0]        cap_peak;
    logic [43:0]        cap_energy;
    logic [31:0]        cap_timeouts;
    logic [1:0]         cap_phase;
    t_fault             cap_fault;
    logic [7:0]         tmo_limit;

    meter_result_t result_q [$];
    int            mismatches;
    int            sent_words;
    bit            src_idle_on;
    bit            sink_stall_on;
    drill_row_t    drill_rows [26];
    logic [7:0]    phase_limits [6];

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic mic_word_t make_word(input logic [2:0] act, input logic [31:0] raw,
                                            input logic [13:0] idx);
        mic_word_t w;
        w.act = act;
        w.raw = raw;
        w.idx = idx;
        return w;
    endfunction

    function automatic meter_result_t predict_meter(input mic_word_t w);
        meter_result_t r;
        int            shifted;
        int            v;
        int            mag;
        r = '0;
        r.status = ST_IGNORED;
        case (w.act)
            ACT_START: begin
                cap_total    = 0;
                cap_run      = 0;
                cap_peak     = '0;
                cap_energy   = '0;
                cap_timeouts = '0;
                cap_fault    = FLT_NONE;
                cap_phase    = PH_RECORDING;
                r.status     = ST_STARTED;
            end
            ACT_SAMPLE: begin
                if (cap_phase == PH_RECORDING && cap_total < STORE_DEPTH) begin
                    shifted = $signed(w.raw) >>> SHIFT_BITS;
                    v = (shifted > 32767) ? 32767 : (shifted < -32768) ? -32768 : shifted;
                    // The most negative sample counts as the largest positive magnitude.
                    mag = (v < 0) ? -v : v;
                    if (mag > 32767) mag = 32767;
                    level_store[cap_total] = 16'(v);
                    cap_total++;
                    cap_run = 0;
                    if (mag > cap_peak) cap_peak = 15'(mag);
                    cap_energy = cap_energy + 44'(mag * mag);
                    r.sample = 16'(v);
                    if (cap_total >= STORE_DEPTH) begin
                        cap_phase = PH_DONE;
                        r.status  = ST_STORED_FULL;
                    end else begin
                        r.status = ST_STORED;
                    end
                end
            end
            ACT_TIMEOUT: begin
                if (cap_phase == PH_RECORDING) begin
                    cap_timeouts++;
                    if (cap_run >= tmo_limit) begin
                        cap_phase = PH_ERROR;
                        cap_fault = FLT_TIMEOUT;
                        r.status  = ST_ERROR;
                    end else begin
                        cap_run++;
                        r.status = ST_TIMEOUT;
                    end
                end
            end
            ACT_STOP: begin
                if (cap_phase == PH_DONE) begin
                    r.status = ST_ALREADY_DONE;
                end else if (cap_phase != PH_RECORDING) begin
                    r.status = ST_NOT_RECORD;
                end else if (cap_total == 0) begin
                    cap_phase = PH_ERROR;
                    cap_fault = FLT_EMPTY;
                    r.status  = ST_ERROR;
                end else begin
                    cap_phase = PH_DONE;
                    r.status  = ST_FINISHED;
                end
            end
            ACT_ABORT: begin
                cap_phase = PH_ERROR;
                cap_fault = FLT_ABORTED;
                r.status  = ST_ERROR;
            end
            ACT_READ: begin
                if (w.idx < cap_total) begin
                    r.sample = level_store[w.idx];
                    r.status = ST_READ_DATA;
                end
            end
            default: ;
        endcase
        r.phase    = cap_phase;
        r.fault    = cap_fault;
        r.total    = 15'(cap_total);
        r.peak     = cap_peak;
        r.energy   = cap_energy;
        r.timeouts = cap_timeouts;
        return r;
    endfunction

    task automatic note_failure(input string what, input meter_result_t want,
                                input meter_result_t seen);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: expected st=%0d ph=%0d err=%0d smp=%0d tot=%0d pk=%0d en=%0d to=%0d",
                     $realtime, what, want.status, want.phase, want.fault, want.sample,
                     want.total, want.peak, want.energy, want.timeouts);
            $display("%0t %s: actual   st=%0d ph=%0d err=%0d smp=%0d tot=%0d pk=%0d en=%0d to=%0d",
                     $realtime, what, seen.status, seen.phase, seen.fault, seen.sample,
                     seen.total, seen.peak, seen.energy, seen.timeouts);
        end
    endtask

    always @(posedge i_clk) begin
        meter_result_t seen;
        meter_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = meter_result_t'(m_axis_tdata[129:0]);
            if (result_q.size() == 0) begin
                note_failure("unexpected result word", '0, seen);
            end else begin
                want = result_q.pop_front();
                if (seen !== want) note_failure("result mismatch", want, seen);
            end
        end
    end

    // Result side: random stall bursts while enabled.
    initial begin
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (sink_stall_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance with
    // tvalid still high, so the caller either sends the next word or drops it.
    task automatic send_word(input mic_word_t w, input bit typed = 1'b0,
                             input meter_result_t typed_res = '0);
        meter_result_t exp_res;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(w);
        do @(posedge i_clk); while (!s_axis_tready);
        exp_res = predict_meter(w);
        if (typed) begin
            exp_res.status = typed_res.status;
            exp_res.phase  = typed_res.phase;
            exp_res.fault  = typed_res.fault;
            exp_res.sample = typed_res.sample;
        end
        sent_words++;
        result_q.push_back(exp_res);
        @(negedge i_clk);
    endtask

    task automatic drop_valid();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_timeout_limit(input logic [7:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        tmo_limit = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] rand_raw();
        logic [31:0] corner [8];
        corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h07FF_F000, 32'hF800_0000, 32'h0800_0000, 32'hF7FF_FFFF};
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return corner[$urandom_range(0, 7)];
            // Mostly words that land inside the 16-bit range after the shift.
            default: return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
        endcase
    endfunction

    function automatic logic [13:0] pick_index();
        if (cap_total > 0 && $urandom_range(0, 5) != 0)
            return 14'($urandom_range(0, cap_total - 1));
        return 14'($urandom);
    endfunction

    task automatic run_capture();
        int n;
        int ending;
        if ($urandom_range(0, 3) == 0)
            n = $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 3);
        else
            n = $urandom_range(1, 20);
        send_word(make_word(ACT_START, $urandom, 14'($urandom)));
        repeat (n) begin
            case ($urandom_range(0, 15))
                0: send_word(make_word(ACT_TIMEOUT, $urandom, 14'($urandom)));
                1: send_word(make_word(ACT_READ, $urandom, pick_index()));
                default: send_word(make_word(ACT_SAMPLE, rand_raw(), 14'($urandom)));
            endcase
        end
        ending = $urandom_range(0, 7);
        if (ending < 5)
            send_word(make_word(ACT_STOP, $urandom, 14'($urandom)));
        else if (ending == 5)
            send_word(make_word(ACT_ABORT, $urandom, 14'($urandom)));
        repeat ($urandom_range(1, 4)) send_word(make_word(ACT_READ, $urandom, pick_index()));
    endtask

    // Timeout runs end right at the limit or one past it.
    task automatic run_timeouts();
        int lead;
        lead = (tmo_limit <= 16) ? $urandom_range(0, tmo_limit) : $urandom_range(0, 8);
        send_word(make_word(ACT_START, $urandom, 14'($urandom)));
        repeat ($urandom_range(0, 3)) send_word(make_word(ACT_SAMPLE, rand_raw(), 14'($urandom)));
        repeat (lead) send_word(make_word(ACT_TIMEOUT, $urandom, 14'($urandom)));
        send_word(make_word(ACT_SAMPLE, rand_raw(), 14'($urandom)));
        repeat (int'(tmo_limit) + $urandom_range(0, 1))
            send_word(make_word(ACT_TIMEOUT, $urandom, 14'($urandom)));
        send_word(make_word(ACT_STOP, $urandom, 14'($urandom)));
    endtask

    task automatic run_noise();
        repeat ($urandom_range(4, 12))
            send_word(make_word(3'($urandom_range(0, 7)), $urandom, 14'($urandom)));
    endtask

    initial begin
        #(5_000_000);
        $display("FAIL mic_capture_level_meter_unit");
        $finish;
    end

    initial begin
        meter_result_t typed_res;
        int            kind;
        int            phase_start;
        int            drain_wait;
        drill_rows = '{
            '{ACT_STOP,    32'h0000_0000, 14'd0,     1'b1, ST_NOT_RECORD,   PH_READY,
              FLT_NONE,    16'sd0},
            '{ACT_SAMPLE,  32'h0001_2345, 14'd0,     1'b1, ST_IGNORED,      PH_READY,
              FLT_NONE,    16'sd0},
            '{ACT_TIMEOUT, 32'h0000_0000, 14'd0,     1'b1, ST_IGNORED,      PH_READY,
              FLT_NONE,    16'sd0},
            '{ACT_READ,    32'h0000_0000, 14'd0,     1'b1, ST_IGNORED,      PH_READY,
              FLT_NONE,    16'sd0},
            '{ACT_START,   32'h0000_0000, 14'd0,     1'b1, ST_STARTED,      PH_RECORDING,
              FLT_NONE,    16'sd0},
            '{ACT_STOP,    32'h0000_0000, 14'd0,     1'b1, ST_ERROR,        PH_ERROR,
              FLT_EMPTY,   16'sd0},
            '{ACT_START,   32'hFFFF_FFFF, 14'h3FFF,  1'b1, ST_STARTED,      PH_RECORDING,
              FLT_NONE,    16'sd0},
            '{ACT_SAMPLE,  32'h7FFF_FFFF, 14'd0,     1'b1, ST_STORED,       PH_RECORDING,
              FLT_NONE,    16'sd32767},
            '{ACT_SAMPLE,  32'h8000_0000, 14'd0,     1'b1, ST_STORED,       PH_RECORDING,
              FLT_NONE,    -16'sd32768},
            '{ACT_SAMPLE,  32'hFFFF_FFFF, 14'd0,     1'b1, ST_STORED,       PH_RECORDING,
              FLT_NONE,    -16'sd1},
            '{ACT_SAMPLE,  32'h0000_0FFF, 14'd0,     1'b1, ST_STORED,       PH_RECORDING,
              FLT_NONE,    16'sd0},
            '{ACT_SAMPLE,  32'h07FF_EFFF, 14'd0,     1'b0, ST_IGNORED,      PH_READY,
              FLT_NONE,    16'sd0},
            '{ACT_SAMPLE,  32'hF800_0000, 14'd0,     1'b0, ST_IGNORED,      PH_READY,
              FLT_NONE,    16'sd0},
            '{ACT_SAMPLE,  32'h0800_0000, 14'd0,     1'b0, ST_IGNORED,      PH_READY,
              FLT_NONE,    16'sd0},
            '{ACT_SAMPLE,  32'h0000_1000, 14'd0,     1'b0, ST_IGNORED,      PH_READY,
              FLT_NONE,    16'sd0},
            '{ACT_TIMEOUT, 32'h0000_0000, 14'd0,     1'b0, ST_IGNORED,      PH_READY,
              FLT_NONE,    16'sd0},
            '{ACT_READ,    32'h0000_0000, 14'd1,     1'b0, ST_IGNORED,      PH_READY,
              FLT_NONE,    16'sd0},
            '{ACT_READ,    32'h0000_0000, 14'h3FFF,  1'b1, ST_IGNORED,      PH_RECORDING,
              FLT_NONE,    16'sd0},
            '{ACT_SPARE6,  32'hFFFF_FFFF, 14'h3FFF,  1'b1, ST_IGNORED,      PH_RECORDING,
              FLT_NONE,    16'sd0},
            '{ACT_SPARE7,  32'h0000_0000, 14'd0,     1'b1, ST_IGNORED,      PH_RECORDING,
              FLT_NONE,    16'sd0},
            '{ACT_STOP,    32'h0000_0000, 14'd0,     1'b1, ST_FINISHED,     PH_DONE,
              FLT_NONE,    16'sd0},
            '{ACT_STOP,    32'h0000_0000, 14'd0,     1'b1, ST_ALREADY_DONE, PH_DONE,
              FLT_NONE,    16'sd0},
            '{ACT_SAMPLE,  32'h0000_5000, 14'd0,     1'b1, ST_IGNORED,      PH_DONE,
              FLT_NONE,    16'sd0},
            '{ACT_ABORT,   32'h0000_0000, 14'd0,     1'b1, ST_ERROR,        PH_ERROR,
              FLT_ABORTED, 16'sd0},
            '{ACT_READ,    32'h0000_0000, 14'd0,     1'b0, ST_IGNORED,      PH_READY,
              FLT_NONE,    16'sd0},
            '{ACT_STOP,    32'h0000_0000, 14'd0,     1'b1, ST_NOT_RECORD,   PH_ERROR,
              FLT_ABORTED, 16'sd0}
        };
        phase_limits = '{8'd0, 8'd255, 8'd3, 8'($urandom_range(4, 254)), 8'd1, 8'd50};

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
        mismatches    = 0;
        sent_words    = 0;
        cap_total     = 0;
        cap_run       = 0;
        cap_peak      = '0;
        cap_energy    = '0;
        cap_timeouts  = '0;
        cap_phase     = PH_READY;
        cap_fault     = FLT_NONE;
        tmo_limit     = TIMEOUT_LIMIT_RESET;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (drill_rows[i]) begin
            typed_res        = '0;
            typed_res.status = drill_rows[i].status;
            typed_res.phase  = drill_rows[i].phase;
            typed_res.fault  = drill_rows[i].fault;
            typed_res.sample = drill_rows[i].sample;
            send_word(make_word(drill_rows[i].act, drill_rows[i].raw, drill_rows[i].idx),
                      drill_rows[i].typed, typed_res);
        end

        // Long timeout runs overshoot the per-phase count, so the target stays low.
        foreach (phase_limits[p]) begin
            drop_valid();
            wait_drained();
            set_timeout_limit(phase_limits[p]);
            phase_start = sent_words;
            while (sent_words - phase_start < 135) begin
                // The final phase runs without idling on either side.
                src_idle_on   = (p != 5) && ($urandom_range(0, 3) != 0);
                sink_stall_on = (p != 5) && ($urandom_range(0, 3) != 0);
                kind = $urandom_range(0, 9);
                if (kind < 5)
                    run_capture();
                else if (kind < 7)
                    run_timeouts();
                else
                    run_noise();
            end
        end

        drop_valid();
        drain_wait = 0;
        while (result_q.size() != 0 && drain_wait < 5000) begin
            @(negedge i_clk);
            drain_wait++;
        end
        repeat (10) @(negedge i_clk);
        while (result_q.size() != 0) note_failure("missing result word", result_q.pop_front(), '0);

        if (mismatches == 0) begin
            $display("PASS mic_capture_level_meter_unit");
        end else begin
            $display("FAIL mic_capture_level_meter_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
sv/mcl_pkg.sv
sv/mcl_store.sv
sv/mcl_ctrl.sv
sv/mic_capture_level_meter_unit.sv
test/tb_mic_capture_level_meter_unit.sv
